>>> sv/tztb_pkg.sv
// ----------------------------------------------------------------------------
// tztb_pkg
// Shared types and constants for the touch zone button tracker.
// ----------------------------------------------------------------------------
package tztb_pkg;

  localparam int NUM_KEYS     = 3;
  localparam int KEY_MARGIN   = 10;
  localparam int COORD_W      = 11;
  localparam int HOLD_W       = 16;
  localparam int TIME_W       = 32;
  localparam int OUT_CNT_W    = 16;
  localparam int CNT_BITS_DEF = 16;

  // Left edge of a key can reach 10 + 2*(2047+10); right edge adds one width
  localparam int EDGE_W = 13;
  // Row bound: row_top + button_height
  localparam int ROW_W  = 12;

  // Register map, byte address = 4 * index
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_ROW_TOP       = 3'd0;
  localparam logic [2:0] REG_BUTTON_WIDTH  = 3'd1;
  localparam logic [2:0] REG_BUTTON_HEIGHT = 3'd2;
  localparam logic [2:0] REG_HOLD_TIME_A   = 3'd3;
  localparam logic [2:0] REG_HOLD_TIME_B   = 3'd4;
  localparam logic [2:0] REG_HOLD_TIME_C   = 3'd5;

  localparam logic [COORD_W-1:0] ROW_TOP_RST       = 11'd620;
  localparam logic [COORD_W-1:0] BUTTON_WIDTH_RST  = 11'd413;
  localparam logic [COORD_W-1:0] BUTTON_HEIGHT_RST = 11'd60;
  localparam logic [HOLD_W-1:0]  HOLD_TIME_A_RST   = 16'd1000;
  localparam logic [HOLD_W-1:0]  HOLD_TIME_B_RST   = 16'd1500;
  localparam logic [HOLD_W-1:0]  HOLD_TIME_C_RST   = 16'd2000;

  typedef struct packed {
    logic               touching;
    logic [COORD_W-1:0] touch_x;
    logic [COORD_W-1:0] touch_y;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           pressed_mask;
    logic [2:0]           press_edge_mask;
    logic [2:0]           release_edge_mask;
    logic [2:0]           held_mask;
    logic [2:0]           long_press_edge_mask;
    logic [OUT_CNT_W-1:0] count_a;
    logic [OUT_CNT_W-1:0] count_b;
    logic [OUT_CNT_W-1:0] count_c;
  } out_item_t;

  // Per-key status after one sample
  typedef struct packed {
    logic pressed;
    logic held;
    logic press_edge;
    logic release_edge;
    logic long_edge;
  } key_stat_t;

  // Per-key geometry and threshold
  typedef struct packed {
    logic [EDGE_W-1:0]  left;
    logic [EDGE_W-1:0]  right;
    logic [ROW_W-1:0]   top;
    logic [ROW_W-1:0]   bottom;
    logic [HOLD_W-1:0]  hold_time;
  } key_cfg_t;

endpackage

>>> sv/tztb_key.sv
// ----------------------------------------------------------------------------
// tztb_key
// One virtual key: hit test, press/release/long-press tracking and counter.
// ----------------------------------------------------------------------------
module tztb_key
  import tztb_pkg::*;
#(
  parameter int COUNT_BITS = CNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  key_cfg_t             kcfg,
  input  in_item_t             item,
  output key_stat_t            stat_nxt,
  output logic [OUT_CNT_W-1:0] count_nxt
);

  logic                  pressed_r;
  logic                  held_r;
  logic [TIME_W-1:0]     start_r;
  logic [COUNT_BITS-1:0] count_r;

  logic                  in_key;
  logic [TIME_W-1:0]     elapsed;
  logic                  reached;
  logic [COUNT_BITS-1:0] count_upd;
  key_stat_t             st;

  assign in_key = item.touching
               && ({2'b00, item.touch_x} >= kcfg.left)
               && ({2'b00, item.touch_x} <  kcfg.right)
               && ({1'b0, item.touch_y}  >= kcfg.top)
               && ({1'b0, item.touch_y}  <  kcfg.bottom);

  assign elapsed = item.now_ms - start_r;

  always_comb begin
    st = '0;
    st.pressed = pressed_r;
    st.held    = held_r;
    reached    = 1'b0;
    if (item.touching) begin
      if (in_key && !pressed_r) begin
        st.pressed    = 1'b1;
        st.held       = 1'b0;
        st.press_edge = 1'b1;
      end else if (!in_key && pressed_r) begin
        st.pressed      = 1'b0;
        st.held         = 1'b0;
        st.release_edge = 1'b1;
      end
      // on a fresh press the elapsed time is zero
      reached = st.press_edge ? (kcfg.hold_time == '0)
                              : (elapsed >= {16'd0, kcfg.hold_time});
      if (st.pressed && !st.held && reached) begin
        st.held      = 1'b1;
        st.long_edge = 1'b1;
      end
    end else if (pressed_r) begin
      st.pressed      = 1'b0;
      st.held         = 1'b0;
      st.release_edge = 1'b1;
    end
  end

  assign count_upd = st.press_edge ? count_r + COUNT_BITS'(1) : count_r;
  assign stat_nxt  = st;

  generate
    if (COUNT_BITS >= OUT_CNT_W) begin : g_wide
      assign count_nxt = count_upd[OUT_CNT_W-1:0];
    end else begin : g_narrow
      assign count_nxt = {{(OUT_CNT_W-COUNT_BITS){1'b0}}, count_upd};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      held_r    <= 1'b0;
      start_r   <= '0;
      count_r   <= '0;
    end else if (upd) begin
      pressed_r <= st.pressed;
      held_r    <= st.held;
      count_r   <= count_upd;
      if (st.press_edge) begin
        start_r <= item.now_ms;
      end
    end
  end

endmodule

>>> sv/touch_zone_button_tracker_core.sv
// ----------------------------------------------------------------------------
// touch_zone_button_tracker_core
// Tracks three virtual keys in one row from a stream of touch samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one touch sample per transaction (touching, x, y, now_ms).
//   out_* : one result per sample: pressed/held state, press, release and
//           long-press edges, and the three press counts.
//   APB   : geometry and hold thresholds at byte addresses 0..20; write only
//           while no sample is in flight. pready is tied high.
// Timing: a sample is taken into an input register; the key logic runs
//   between that register and the result register; a result shows on
//   out_valid from the result register. One sample per cycle is sustained
//   while out_stall is low; the key state feeds back within that single stage.
// Stall: out_stall holds the result register; the input register still
//   takes one more sample if it is empty, after which in_stall rises.
// Reset: synchronous on rst_n low; keys released, counts and start times
//   cleared, registers back to their defaults, both channels empty.
// ----------------------------------------------------------------------------
module touch_zone_button_tracker_core
  import tztb_pkg::*;
#(
  parameter int COUNT_BITS = CNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [COORD_W-1:0] row_top_r;
  logic [COORD_W-1:0] button_width_r;
  logic [COORD_W-1:0] button_height_r;
  logic [HOLD_W-1:0]  hold_r [NUM_KEYS];

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      out_load;
  logic      advance;
  logic      cfg_wr;
  logic [2:0] cfg_idx;

  key_cfg_t             kcfg  [NUM_KEYS];
  key_stat_t            kstat [NUM_KEYS];
  logic [OUT_CNT_W-1:0] kcnt  [NUM_KEYS];
  out_item_t            out_item_nxt;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_ROW_TOP:       prdata = {21'd0, row_top_r};
      REG_BUTTON_WIDTH:  prdata = {21'd0, button_width_r};
      REG_BUTTON_HEIGHT: prdata = {21'd0, button_height_r};
      REG_HOLD_TIME_A:   prdata = {16'd0, hold_r[0]};
      REG_HOLD_TIME_B:   prdata = {16'd0, hold_r[1]};
      REG_HOLD_TIME_C:   prdata = {16'd0, hold_r[2]};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_top_r       <= ROW_TOP_RST;
      button_width_r  <= BUTTON_WIDTH_RST;
      button_height_r <= BUTTON_HEIGHT_RST;
      hold_r[0]       <= HOLD_TIME_A_RST;
      hold_r[1]       <= HOLD_TIME_B_RST;
      hold_r[2]       <= HOLD_TIME_C_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROW_TOP:       row_top_r       <= pwdata[COORD_W-1:0];
        REG_BUTTON_WIDTH:  button_width_r  <= pwdata[COORD_W-1:0];
        REG_BUTTON_HEIGHT: button_height_r <= pwdata[COORD_W-1:0];
        REG_HOLD_TIME_A:   hold_r[0]       <= pwdata[HOLD_W-1:0];
        REG_HOLD_TIME_B:   hold_r[1]       <= pwdata[HOLD_W-1:0];
        REG_HOLD_TIME_C:   hold_r[2]       <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  assign out_load  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_load;
  assign in_stall  = s1_valid_r && !out_load;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  // ---------------- keys ----------------
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    logic [EDGE_W-1:0] left;
    // left = margin + k * (width + margin); constant k
    assign left = EDGE_W'(KEY_MARGIN)
                + EDGE_W'(k) * ({2'b00, button_width_r} + EDGE_W'(KEY_MARGIN));
    assign kcfg[k].left      = left;
    assign kcfg[k].right     = left + {2'b00, button_width_r};
    assign kcfg[k].top       = {1'b0, row_top_r};
    assign kcfg[k].bottom    = {1'b0, row_top_r} + {1'b0, button_height_r};
    assign kcfg[k].hold_time = hold_r[k];

    tztb_key #(
      .COUNT_BITS(COUNT_BITS)
    ) u_key (
      .clk       (clk),
      .rst_n     (rst_n),
      .upd       (advance),
      .kcfg      (kcfg[k]),
      .item      (s1_item_r),
      .stat_nxt  (kstat[k]),
      .count_nxt (kcnt[k])
    );

    assign out_item_nxt.pressed_mask[k]         = kstat[k].pressed;
    assign out_item_nxt.press_edge_mask[k]      = kstat[k].press_edge;
    assign out_item_nxt.release_edge_mask[k]    = kstat[k].release_edge;
    assign out_item_nxt.held_mask[k]            = kstat[k].held;
    assign out_item_nxt.long_press_edge_mask[k] = kstat[k].long_edge;
  end

  assign out_item_nxt.count_a = kcnt[0];
  assign out_item_nxt.count_b = kcnt[1];
  assign out_item_nxt.count_c = kcnt[2];

`ifndef SYNTH
  a_held_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_item_r.held_mask & ~out_item_r.pressed_mask) == 3'd0))
    else $error("held key not pressed");

  a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((out_item_r.press_edge_mask & out_item_r.release_edge_mask) == 3'd0))
    else $error("press and release edge on same key");

  a_long_edge_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((out_item_r.long_press_edge_mask & ~out_item_r.held_mask) == 3'd0))
    else $error("long-press edge without held");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((out_item_r.release_edge_mask & out_item_r.pressed_mask) == 3'd0))
    else $error("released key still pressed");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in pipeline");
`endif

endmodule
